@@ sv/sort_then_sorted_insert_top_assert.svh @@
// Assertion macros used by the top RTL file of the sorted insertion block.
`ifndef SORT_THEN_SORTED_INSERT_TOP_ASSERT_SVH
`define SORT_THEN_SORTED_INSERT_TOP_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define STSI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted insertion check failed");

// The consequent must hold in the cycle after the antecedent.
`define STSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted insertion check failed");

`else

`define STSI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/stsi_pkg.sv @@
package stsi_pkg;

    // Store geometry.
    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic [POS_W-1:0]         position;
        logic                     last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_SWAP = 3'b100
    } state_t;

endpackage

@@ sv/sort_then_sorted_insert_top.sv @@
// Sorted insertion block. A load request returns no result. An insert request
// over n loaded values makes n+1 selection passes, each reading the unsorted tail
// through the single RAM read port and then swapping and emitting its minimum.
// Results cannot be stalled. Reset clears the count and the control state; the
// RAM contents stay undefined and are never read before being written.
`include "sort_then_sorted_insert_top_assert.svh"

module sort_then_sorted_insert_top
    import stsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic rsp_valid,
    output rsp_t rsp
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         pass_reg, pass_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     dvalid_reg, dvalid_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]         didx_reg, didx_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] first_reg, first_next;
    rsp_t                     rsp_reg, rsp_next;

    logic                     accept;
    logic                     issue;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic [DATA_W-1:0]        wdata;
    logic signed [DATA_W-1:0] rdata;

    // Element store.
    stsi_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign issue  = (state_reg == ST_SCAN) && (rd_idx_reg <= n_reg);

    // Write port: loads (unless the store is full) and the inserted value are appended, a swap writes back.
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        wdata = req.value;
        if (accept)
        begin
            if (req.command == CMD_INSERT)
            begin
                we = 1'b1;
            end
            else
            begin
                we = (count_reg < CNT_W'(CAPACITY - 1));
            end
        end
        else if (state_reg == ST_SWAP)
        begin
            we    = 1'b1;
            waddr = lo_reg[IDX_W-1:0];
            wdata = first_reg;
        end
    end

    // Sequencer: count loads; on an insert, scan the tail for its minimum, then swap and emit it.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        pass_next      = pass_reg;
        rd_idx_next    = rd_idx_reg;
        dvalid_next    = issue;
        rsp_valid_next = 1'b0;
        didx_next      = rd_idx_reg;
        lo_next        = lo_reg;
        min_next       = min_reg;
        first_next     = first_reg;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_INSERT)
                    begin
                        n_next      = count_reg;
                        pass_next   = '0;
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else if (count_reg < CNT_W'(CAPACITY - 1))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (dvalid_reg)
                begin
                    if (didx_reg == pass_reg)
                    begin
                        first_next = rdata;
                        min_next   = rdata;
                        lo_next    = pass_reg;
                    end
                    else if (rdata < min_reg)
                    begin
                        min_next = rdata;
                        lo_next  = didx_reg;
                    end
                    if (didx_reg == n_reg)
                    begin
                        state_next = ST_SWAP;
                    end
                end
            end

            ST_SWAP:
            begin
                rsp_valid_next        = 1'b1;
                rsp_next.sorted_value = min_reg;
                rsp_next.position     = POS_W'(pass_reg);
                rsp_next.last         = (pass_reg == n_reg);
                if (pass_reg == n_reg)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pass_next   = pass_reg + 1'b1;
                    rd_idx_next = pass_reg + 1'b1;
                    state_next  = ST_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            pass_reg      <= '0;
            rd_idx_reg    <= '0;
            dvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            pass_reg      <= pass_next;
            rd_idx_reg    <= rd_idx_next;
            dvalid_reg    <= dvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        didx_reg  <= didx_next;
        lo_reg    <= lo_next;
        min_reg   <= min_next;
        first_reg <= first_next;
        rsp_reg   <= rsp_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted insert starts the sort right away.
    `STSI_ASSERT_NEXT(a_insert_busy, clk, rst_n, accept && (req.command == CMD_INSERT), busy)
    // More results follow any result that is not the last.
    `STSI_ASSERT_NEXT(a_more_follow, clk, rst_n, rsp_valid && !rsp.last, busy)
    // The last result coincides with the return to idle.
    `STSI_ASSERT_SAME(a_last_idle, clk, rst_n, rsp_valid && rsp.last, !busy && (count_reg == '0))
    // A pass never runs beyond the last list index.
    `STSI_ASSERT_SAME(a_pass_range, clk, rst_n, state_reg != ST_IDLE, pass_reg <= n_reg)

endmodule

@@ sv/stsi_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module stsi_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, with registered data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/stsi_checker.sv @@
module stsi_checker
    import stsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic rsp_valid,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    // Shadow copy of the element store and of the loaded count.
    logic signed [DATA_W-1:0] list_store [CAPACITY];
    int                       list_count = 0;

    // Sorted elements still to be emitted, oldest first.
    rsp_t                     pending_elems [$];
    rsp_t                     want_elem;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sort the loaded values, place the new one after any equal values,
    // and queue the whole list for emission.
    task automatic insert_sorted(input logic signed [DATA_W-1:0] v);
        int                       n;
        int                       lo;
        int                       slot;
        logic signed [DATA_W-1:0] tmp;
        rsp_t                     elem;
        n = list_count;
        for (int i = 0; i + 1 < n; i++)
        begin
            lo = i;
            for (int j = i + 1; j < n; j++)
            begin
                if (list_store[lo] > list_store[j])
                    lo = j;
            end
            tmp            = list_store[lo];
            list_store[lo] = list_store[i];
            list_store[i]  = tmp;
        end
        slot = n;
        for (int i = 0; i < n; i++)
        begin
            if (v < list_store[i])
            begin
                slot = i;
                break;
            end
        end
        for (int i = n; i > slot; i--)
            list_store[i] = list_store[i - 1];
        list_store[slot] = v;
        for (int i = 0; i <= n; i++)
        begin
            elem.sorted_value = list_store[i];
            elem.position     = POS_W'(i);
            elem.last         = (i == n);
            pending_elems.push_back(elem);
        end
        list_count = 0;
    endtask

    // Check results first, then account for a newly accepted request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid)
            begin
                if (pending_elems.size() == 0)
                begin
                    report_error($sformatf("unexpected result: value %0d position %0d last %0b",
                                           rsp.sorted_value, rsp.position, rsp.last));
                end
                else
                begin
                    want_elem = pending_elems.pop_front();
                    if (rsp.sorted_value !== want_elem.sorted_value)
                        report_error($sformatf("sorted_value %0d, expected %0d at position %0d",
                                               rsp.sorted_value, want_elem.sorted_value,
                                               want_elem.position));
                    if (rsp.position !== want_elem.position)
                        report_error($sformatf("position %0d, expected %0d",
                                               rsp.position, want_elem.position));
                    if (rsp.last !== want_elem.last)
                        report_error($sformatf("last %0b, expected %0b at position %0d",
                                               rsp.last, want_elem.last, want_elem.position));
                end
            end
            if (start && !busy)
            begin
                if (req.command == CMD_INSERT)
                    insert_sorted(req.value);
                else if (list_count < CAPACITY - 1)
                begin
                    // A load into a full store is dropped.
                    list_store[list_count] = req.value;
                    list_count++;
                end
            end
            outstanding = pending_elems.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import stsi_pkg::*;
;

    localparam int RANDOM_ITEMS   = 310;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic rsp_valid;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;

    // Stimulus bookkeeping.
    int   idle_pct     = 0;
    int   items        = 0;
    int   loaded       = 0;
    int   random_base  = 0;
    int   quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sort_then_sorted_insert_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    stsi_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Stop a hung run: count cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || rsp_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one request, entered and left at a falling edge. Idle cycles carry noise.
    task automatic send_req(input logic cmd, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < idle_pct)
        begin
            start       = 1'b0;
            req.command = 1'($urandom_range(1));
            req.value   = $urandom;
            @(negedge clk);
        end
        start       = 1'b1;
        req.command = cmd;
        req.value   = val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_INSERT)
        begin
            items++;
            loaded = 0;
        end
        else if (loaded < CAPACITY - 1)
        begin
            items++;
            loaded++;
        end
        @(negedge clk);
    endtask

    // Hold off the sender until every queued element has come out.
    task automatic drain_results();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Mode 0: any value, 1: a narrow band for duplicates, 2: corners, 3: a mix.
    function automatic logic signed [DATA_W-1:0] pick_value(input int mode);
        int m;
        m = (mode == 3) ? $urandom_range(2) : mode;
        case (m)
            0: pick_value = $urandom;
            1: pick_value = $signed($urandom_range(6)) - 3;
            default:
            begin
                case ($urandom_range(5))
                    0:       pick_value = VAL_MIN;
                    1:       pick_value = VAL_MIN + 1;
                    2:       pick_value = VAL_MAX;
                    3:       pick_value = VAL_MAX - 1;
                    4:       pick_value = 0;
                    default: pick_value = -1;
                endcase
            end
        endcase
    endfunction

    // One list: a run of loads, mostly short, sometimes past the store's capacity,
    // closed by an insert.
    task automatic random_list();
        int n;
        int r;
        int mode;
        r    = $urandom_range(99);
        mode = $urandom_range(3);
        if (r < 72)
            n = $urandom_range(8);
        else if (r < 90)
            n = $urandom_range(20, 9);
        else
            n = $urandom_range(CAPACITY + 2, CAPACITY - 2);
        repeat (n)
            send_req(CMD_LOAD, pick_value(mode));
        send_req(CMD_INSERT, pick_value(mode));
    endtask

    initial
    begin
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Insert into an empty store.
        send_req(CMD_INSERT, 5);
        send_req(CMD_INSERT, VAL_MIN);
        // Extremes, with an insert equal to a stored value.
        send_req(CMD_LOAD, VAL_MAX);
        send_req(CMD_LOAD, VAL_MIN);
        send_req(CMD_LOAD, 0);
        send_req(CMD_LOAD, -1);
        send_req(CMD_LOAD, 1);
        send_req(CMD_INSERT, 0);
        // Duplicates: the new value goes after the equal ones.
        send_req(CMD_LOAD, 7);
        send_req(CMD_LOAD, 7);
        send_req(CMD_LOAD, 3);
        send_req(CMD_INSERT, 7);
        // Insert at the head and at the tail.
        send_req(CMD_LOAD, 2);
        send_req(CMD_LOAD, 1);
        send_req(CMD_INSERT, VAL_MIN);
        send_req(CMD_LOAD, VAL_MIN);
        send_req(CMD_INSERT, VAL_MAX);
        send_req(CMD_LOAD, VAL_MAX);
        send_req(CMD_INSERT, VAL_MAX);
        drain_results();

        // Random lists in three idling phases, draining between them.
        random_base = items;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       idle_pct = 0;
                1:       idle_pct = 87;
                default: idle_pct = 10;
            endcase
            while (items < random_base + (phase + 1) * RANDOM_ITEMS / 3)
                random_list();
            drain_results();
        end

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
